/* design/efc_pkg.sv */
`default_nettype none

package efc_pkg;

  localparam int FLOORS  = 4;
  localparam int FLOOR_W = $clog2(FLOORS);
  localparam int HALL_W  = FLOORS - 1;
  localparam int DOOR_W  = 16;

  localparam logic [DOOR_W-1:0] DOOR_TICKS_RESET = 16'd120;

  // operating modes
  localparam logic [2:0] M_HOMING       = 3'd0;
  localparam logic [2:0] M_IDLE         = 3'd1;
  localparam logic [2:0] M_MOVING       = 3'd2;
  localparam logic [2:0] M_DOOR         = 3'd3;
  localparam logic [2:0] M_STOP_BETWEEN = 3'd4;
  localparam logic [2:0] M_STOP_FLOOR   = 3'd5;
  localparam logic [2:0] M_STOP_DOOR    = 3'd6;

  // motor commands
  localparam logic signed [1:0] MOTOR_DOWN = 2'sb11;
  localparam logic signed [1:0] MOTOR_STOP = 2'sb00;
  localparam logic signed [1:0] MOTOR_UP   = 2'sb01;

  typedef struct packed {
    logic signed [2:0] floor_sensor;
    logic [2:0]        hall_up_buttons;
    logic [2:0]        hall_down_buttons;
    logic [3:0]        cab_buttons;
    logic              stop_button;
    logic              obstruction;
  } in_item_t;

  typedef struct packed {
    logic signed [1:0] motor_drive;
    logic [1:0]        floor_indicator;
    logic              door_lamp;
    logic              stop_lamp;
    logic [2:0]        hall_up_lamps;
    logic [2:0]        hall_down_lamps;
    logic [3:0]        cab_lamps;
  } out_item_t;

  // up[i]: floor i, dn[i]: floor i+1, cab[i]: floor i
  typedef struct packed {
    logic [FLOORS-1:0] cab;
    logic [HALL_W-1:0] dn;
    logic [HALL_W-1:0] up;
  } orders_t;

  typedef struct packed {
    orders_t            orders;
    logic [FLOOR_W-1:0] last_floor;
    logic [FLOOR_W-1:0] target_floor;
    logic               dir_up;
    logic [2:0]         mode;
    logic [DOOR_W-1:0]  door_count;
    logic               resume_travel;
  } efc_state_t;

  localparam efc_state_t STATE_RESET = '{
    orders:        '0,
    last_floor:    '0,
    target_floor:  '0,
    dir_up:        1'b0,
    mode:          M_HOMING,
    door_count:    '0,
    resume_travel: 1'b0
  };

endpackage

`default_nettype wire

/* design/efc_core.sv */
`default_nettype none

module efc_core
  import efc_pkg::*;
(
  input  efc_state_t        state_cur,
  input  in_item_t          item,
  input  logic [DOOR_W-1:0] door_ticks,
  output efc_state_t        state_nxt,
  output out_item_t         result
);

  function automatic orders_t orders_clear(input orders_t o, input logic [FLOOR_W-1:0] f,
                                           input logic clr_up, input logic clr_dn);
    logic [FLOORS-1:0] up_w;
    logic [FLOORS-1:0] dn_w;
    logic [FLOORS-1:0] cab_w;
    orders_t r;
    up_w  = {1'b0, o.up};
    dn_w  = {o.dn, 1'b0};
    cab_w = o.cab;
    cab_w[f] = 1'b0;
    if (clr_up) up_w[f] = 1'b0;
    if (clr_dn) dn_w[f] = 1'b0;
    r.up  = up_w[HALL_W-1:0];
    r.dn  = dn_w[FLOORS-1:1];
    r.cab = cab_w;
    return r;
  endfunction

  logic [2:0]         raw;
  logic               at_floor;
  logic [FLOOR_W-1:0] fl;
  logic               stop;
  logic               obst;
  logic [2:0]         mode_cur;
  logic [DOOR_W-1:0]  door_load;
  orders_t            latched;
  logic [FLOORS-1:0]  up_w;
  logic [FLOORS-1:0]  dn_w;
  logic [FLOORS-1:0]  any_order;
  logic [FLOOR_W-1:0] first_floor;
  logic [FLOOR_W-1:0] move_last;
  logic               move_dir;
  logic               stop_here;

  assign raw      = item.floor_sensor;
  assign at_floor = !raw[2] && (raw < 3'(FLOORS));
  assign fl       = raw[FLOOR_W-1:0];
  assign stop     = item.stop_button;
  assign obst     = item.obstruction;
  assign mode_cur = (state_cur.mode > M_STOP_DOOR) ? M_HOMING : state_cur.mode;
  assign door_load = (door_ticks == '0) ? DOOR_W'(1) : door_ticks;

  assign latched.up  = state_cur.orders.up  | item.hall_up_buttons[HALL_W-1:0];
  assign latched.dn  = state_cur.orders.dn  | item.hall_down_buttons[HALL_W-1:0];
  assign latched.cab = state_cur.orders.cab | item.cab_buttons[FLOORS-1:0];

  assign up_w      = {1'b0, latched.up};
  assign dn_w      = {latched.dn, 1'b0};
  assign any_order = latched.cab | up_w | dn_w;

  // lowest floor with any order
  always_comb begin
    first_floor = '0;
    for (int i = FLOORS - 1; i >= 0; i--) begin
      if (any_order[i]) first_floor = FLOOR_W'(i);
    end
  end

  assign move_last = at_floor ? fl : state_cur.last_floor;
  assign move_dir  = !(state_cur.target_floor < move_last);
  assign stop_here = latched.cab[fl] || (move_dir && up_w[fl]) || (!move_dir && dn_w[fl]);

  always_comb begin
    state_nxt = state_cur;
    state_nxt.mode = mode_cur;
    case (mode_cur)
      M_HOMING: begin
        if (at_floor && fl == '0) begin
          state_nxt.last_floor   = '0;
          state_nxt.target_floor = '0;
          state_nxt.dir_up       = 1'b0;
          state_nxt.mode         = M_IDLE;
        end
      end
      M_IDLE: begin
        if (stop) begin
          state_nxt.orders        = '0;
          state_nxt.target_floor  = state_cur.last_floor;
          state_nxt.resume_travel = 1'b0;
          state_nxt.mode          = at_floor ? M_STOP_FLOOR : M_STOP_BETWEEN;
        end else begin
          state_nxt.orders = latched;
          if (|any_order) begin
            state_nxt.target_floor = first_floor;
            state_nxt.dir_up       = !(first_floor < state_cur.last_floor);
            if (first_floor == state_cur.last_floor) begin
              state_nxt.mode          = M_DOOR;
              state_nxt.door_count    = door_load;
              state_nxt.resume_travel = 1'b0;
            end else begin
              state_nxt.mode = M_MOVING;
            end
          end
        end
      end
      M_MOVING: begin
        if (stop) begin
          state_nxt.orders        = '0;
          state_nxt.target_floor  = state_cur.last_floor;
          state_nxt.resume_travel = 1'b0;
          state_nxt.mode          = at_floor ? M_STOP_FLOOR : M_STOP_BETWEEN;
        end else begin
          state_nxt.orders     = latched;
          state_nxt.last_floor = move_last;
          state_nxt.dir_up     = move_dir;
          if (at_floor && (fl == state_cur.target_floor || stop_here)) begin
            state_nxt.mode          = M_DOOR;
            state_nxt.door_count    = door_load;
            state_nxt.resume_travel = (fl != state_cur.target_floor);
          end
        end
      end
      M_DOOR: begin
        if (!stop) state_nxt.orders = latched;
        if (stop || obst) begin
          state_nxt.door_count = door_load;
        end else if (state_cur.door_count <= DOOR_W'(1)) begin
          state_nxt.door_count    = '0;
          state_nxt.resume_travel = 1'b0;
          if (state_cur.resume_travel) begin
            // intermediate stop: drop the cab call and only the hall call in the travel direction
            state_nxt.orders = orders_clear(latched, state_cur.last_floor,
                                            state_cur.dir_up, !state_cur.dir_up);
            state_nxt.dir_up = !(state_cur.target_floor < state_cur.last_floor);
            state_nxt.mode   = M_MOVING;
          end else begin
            state_nxt.orders = orders_clear(latched, state_cur.last_floor, 1'b1, 1'b1);
            state_nxt.mode   = M_IDLE;
          end
        end else begin
          state_nxt.door_count = state_cur.door_count - DOOR_W'(1);
        end
      end
      M_STOP_BETWEEN: begin
        if (stop) begin
          if (at_floor) state_nxt.mode = M_STOP_FLOOR;
        end else begin
          state_nxt.mode          = M_HOMING;
          state_nxt.last_floor    = '0;
          state_nxt.target_floor  = '0;
          state_nxt.door_count    = '0;
          state_nxt.resume_travel = 1'b0;
        end
      end
      M_STOP_FLOOR: begin
        if (!stop) begin
          state_nxt.mode       = M_STOP_DOOR;
          state_nxt.door_count = door_load;
        end
      end
      M_STOP_DOOR: begin
        if (stop || obst) begin
          state_nxt.door_count = door_load;
        end else if (state_cur.door_count <= DOOR_W'(1)) begin
          state_nxt.mode          = M_HOMING;
          state_nxt.last_floor    = '0;
          state_nxt.target_floor  = '0;
          state_nxt.door_count    = '0;
          state_nxt.resume_travel = 1'b0;
        end else begin
          state_nxt.door_count = state_cur.door_count - DOOR_W'(1);
        end
      end
      default: begin
        state_nxt.mode = M_HOMING;
      end
    endcase
  end

  always_comb begin
    if (state_nxt.mode == M_HOMING) begin
      result.motor_drive = MOTOR_DOWN;
    end else if (state_nxt.mode == M_MOVING) begin
      result.motor_drive = state_nxt.dir_up ? MOTOR_UP : MOTOR_DOWN;
    end else begin
      result.motor_drive = MOTOR_STOP;
    end
    result.floor_indicator = state_nxt.last_floor;
    result.door_lamp       = (state_nxt.mode == M_DOOR) || (state_nxt.mode == M_STOP_FLOOR) ||
                             (state_nxt.mode == M_STOP_DOOR);
    result.stop_lamp       = stop;
    result.hall_up_lamps   = state_nxt.orders.up;
    result.hall_down_lamps = state_nxt.orders.dn;
    result.cab_lamps       = state_nxt.orders.cab;
  end

endmodule

`default_nettype wire

/* design/elevator_floor_controller.sv */
// Elevator floor controller: one poll tick per beat.
//
// Input channel (in_valid / in_ready / in_item): one beat per poll tick with
// the floor sensor, hall and cab buttons, stop button and obstruction switch.
// Result channel (out_valid / out_ready / out_item): exactly one beat per input
// beat with motor command, floor indicator, door and stop lamps and the order
// lamps, in input order.
// Configuration: cfg_wr_en with cfg_wr_data writes door_ticks (reset 120);
// write it only while no beat is in flight.
//
// An accepted input beat goes into the input register and from there into the result
// register (one input register, one result register). Throughput: one beat per cycle
// while out_ready holds; the whole tick update is one pass of logic between those two
// registers, and the controller state is updated as the result is registered.
// Reset (rst_n low, synchronous): orders cleared, car homing towards floor 0,
// both channels empty.
// Stall: while out_ready is low the result register holds; one more beat is
// taken into the input register, after which in_ready drops.
`default_nettype none

module elevator_floor_controller
  import efc_pkg::*;
(
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  wire               out_ready,
  output out_item_t         out_item,
  input  wire               cfg_wr_en,
  input  wire [DOOR_W-1:0]  cfg_wr_data
);

  logic              in_valid_r;
  in_item_t          in_item_r;
  logic              out_valid_r;
  out_item_t         out_item_r;
  efc_state_t        state_r;
  efc_state_t        state_nxt;
  logic [DOOR_W-1:0] door_ticks_r;
  out_item_t         result;
  logic              s1_fire;

  assign s1_fire   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || s1_fire;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  efc_core u_core (
    .state_cur  (state_r),
    .item       (in_item_r),
    .door_ticks (door_ticks_r),
    .state_nxt  (state_nxt),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      state_r      <= STATE_RESET;
      door_ticks_r <= DOOR_TICKS_RESET;
    end else begin
      if (cfg_wr_en) door_ticks_r <= cfg_wr_data;
      if (in_ready) in_valid_r <= in_valid;
      if (s1_fire) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_item_r <= in_item;
    if (s1_fire) out_item_r <= result;
  end

  // hold a waiting input beat until it moves on
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !s1_fire |=> in_valid_r && $stable(in_item_r))
    else $error("input register lost or changed a waiting beat");

  a_state_only_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(state_r))
    else $error("controller state changed without a beat");

  a_door_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.mode == M_DOOR || state_r.mode == M_STOP_DOOR) |-> state_r.door_count != '0)
    else $error("door hold with zero count");

  a_door_motor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.door_lamp |-> out_item_r.motor_drive == MOTOR_STOP)
    else $error("motor driven with door open");

endmodule

`default_nettype wire

/* dv/elevator_floor_controller_tb.sv */
`timescale 1ns / 1ps

module elevator_floor_controller_tb;
  import efc_pkg::*;

  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int TICKS_PER_PHASE = 108;
  localparam int PHASES          = 9;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_item;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_item;
  logic              cfg_wr_en;
  logic [DOOR_W-1:0] cfg_wr_data;

  elevator_floor_controller uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Car controller state as predicted from the accepted ticks
  orders_t            car_orders;
  logic [FLOOR_W-1:0] car_floor;
  logic [FLOOR_W-1:0] car_target;
  logic               car_dir_up;
  logic [2:0]         car_mode;
  logic [DOOR_W-1:0]  car_door_count;
  logic               car_resume;
  logic [DOOR_W-1:0]  door_ticks_set;

  out_item_t panel_due [$];
  out_item_t last_panel;

  // Shaft model driving the floor sensor: even notches are floors
  int plant_pos, plant_cnt, plant_step;
  int stop_left, obst_left;

  bit calm;
  bit stall_req;
  int stall_left;
  int errors, beats_checked, ticks_sent, door_opens, stop_presses, idle_cycles;

  typedef struct {
    in_item_t  tick;
    int        reps;
    bit        typed;
    out_item_t want;
  } script_row_t;

  script_row_t script [$];
  logic [DOOR_W-1:0] door_plan [PHASES];

  function automatic logic [DOOR_W-1:0] door_reload();
    return (door_ticks_set == '0) ? 16'd1 : door_ticks_set;
  endfunction

  function automatic logic order_at_floor(input int f);
    return car_orders.cab[f] ||
           ((f < FLOORS - 1) ? car_orders.up[f] : 1'b0) ||
           ((f >= 1) ? car_orders.dn[f-1] : 1'b0);
  endfunction

  function automatic void clear_floor(input int f, input bit up, input bit down);
    car_orders.cab[f] = 1'b0;
    if (up && f < FLOORS - 1) car_orders.up[f] = 1'b0;
    if (down && f >= 1) car_orders.dn[f-1] = 1'b0;
  endfunction

  function automatic void take_buttons(input in_item_t it);
    car_orders.up  = car_orders.up | it.hall_up_buttons;
    car_orders.dn  = car_orders.dn | it.hall_down_buttons;
    car_orders.cab = car_orders.cab | it.cab_buttons;
  endfunction

  function automatic void open_door(input bit resume);
    car_mode       = M_DOOR;
    car_door_count = door_reload();
    car_resume     = resume;
  endfunction

  function automatic void go_home();
    car_mode       = M_HOMING;
    car_floor      = '0;
    car_target     = '0;
    car_door_count = '0;
    car_resume     = 1'b0;
  endfunction

  function automatic void reset_car();
    car_orders     = STATE_RESET.orders;
    car_floor      = STATE_RESET.last_floor;
    car_target     = STATE_RESET.target_floor;
    car_dir_up     = STATE_RESET.dir_up;
    car_mode       = STATE_RESET.mode;
    car_door_count = STATE_RESET.door_count;
    car_resume     = STATE_RESET.resume_travel;
    door_ticks_set = DOOR_TICKS_RESET;
  endfunction

  // One poll tick of the controller; returns the panel it shows afterwards
  function automatic out_item_t advance_car(input in_item_t it);
    out_item_t          p;
    int unsigned        raw;
    logic               at_floor;
    logic [FLOOR_W-1:0] fl;
    int                 fi;
    int                 found;
    logic               hall_up, hall_dn;
    raw      = {29'd0, it.floor_sensor};
    at_floor = (raw < FLOORS);
    fl       = at_floor ? raw[FLOOR_W-1:0] : '0;
    fi       = int'(fl);
    found    = -1;
    if (car_mode > M_STOP_DOOR) car_mode = M_HOMING;
    case (car_mode)
      M_HOMING: begin
        if (at_floor && fl == '0) begin
          car_floor  = '0;
          car_target = '0;
          car_dir_up = 1'b0;
          car_mode   = M_IDLE;
        end
      end
      M_IDLE, M_MOVING: begin
        if (it.stop_button) begin
          car_orders = '0;
          car_target = car_floor;
          car_resume = 1'b0;
          car_mode   = at_floor ? M_STOP_FLOOR : M_STOP_BETWEEN;
        end else begin
          take_buttons(it);
          if (car_mode == M_IDLE) begin
            for (int f = 0; f < FLOORS; f++)
              if (found < 0 && order_at_floor(f)) found = f;
            if (found >= 0) begin
              car_target = found[FLOOR_W-1:0];
              car_dir_up = !(car_target < car_floor);
              if (car_target == car_floor) open_door(1'b0);
              else car_mode = M_MOVING;
            end
          end else begin
            if (at_floor) car_floor = fl;
            car_dir_up = !(car_target < car_floor);
            if (at_floor) begin
              hall_up = (fi < FLOORS - 1) ? car_orders.up[fi] : 1'b0;
              hall_dn = (fi >= 1) ? car_orders.dn[fi-1] : 1'b0;
              if (fl == car_target) open_door(1'b0);
              else if (car_orders.cab[fi] || (car_dir_up && hall_up) ||
                       (!car_dir_up && hall_dn))
                open_door(1'b1);
            end
          end
        end
      end
      M_DOOR: begin
        if (!it.stop_button) take_buttons(it);
        if (it.stop_button || it.obstruction) begin
          car_door_count = door_reload();
        end else if (car_door_count <= 16'd1) begin
          car_door_count = '0;
          if (car_resume) begin
            clear_floor(int'(car_floor), car_dir_up, !car_dir_up);
            car_dir_up = !(car_target < car_floor);
            car_mode   = M_MOVING;
          end else begin
            clear_floor(int'(car_floor), 1'b1, 1'b1);
            car_mode = M_IDLE;
          end
          car_resume = 1'b0;
        end else begin
          car_door_count = car_door_count - 16'd1;
        end
      end
      M_STOP_BETWEEN: begin
        if (!it.stop_button) go_home();
        else if (at_floor) car_mode = M_STOP_FLOOR;
      end
      M_STOP_FLOOR: begin
        if (!it.stop_button) begin
          car_mode       = M_STOP_DOOR;
          car_door_count = door_reload();
        end
      end
      default: begin
        if (it.stop_button || it.obstruction) car_door_count = door_reload();
        else if (car_door_count <= 16'd1) go_home();
        else car_door_count = car_door_count - 16'd1;
      end
    endcase

    if (car_mode == M_HOMING) p.motor_drive = MOTOR_DOWN;
    else if (car_mode == M_MOVING) p.motor_drive = car_dir_up ? MOTOR_UP : MOTOR_DOWN;
    else p.motor_drive = MOTOR_STOP;
    p.floor_indicator = car_floor;
    p.door_lamp       = (car_mode == M_DOOR) || (car_mode == M_STOP_FLOOR) ||
                        (car_mode == M_STOP_DOOR);
    p.stop_lamp       = it.stop_button;
    p.hall_up_lamps   = car_orders.up;
    p.hall_down_lamps = car_orders.dn;
    p.cab_lamps       = car_orders.cab;
    return p;
  endfunction

  function automatic out_item_t panel(input logic signed [1:0] motor,
                                      input logic [1:0] fl, input logic door,
                                      input logic stop, input logic [2:0] up,
                                      input logic [2:0] dn, input logic [3:0] cab);
    out_item_t p;
    p = '{motor, fl, door, stop, up, dn, cab};
    return p;
  endfunction

  function automatic script_row_t row(input logic [2:0] sensor, input logic [2:0] up,
                                      input logic [2:0] dn, input logic [3:0] cab,
                                      input logic stop, input logic obst, input int reps,
                                      input bit typed, input out_item_t want);
    script_row_t r;
    r.tick  = '{sensor, up, dn, cab, stop, obst};
    r.reps  = reps;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  function automatic logic [3:0] press_bits();
    logic [3:0] b;
    for (int i = 0; i < 4; i++) b[i] = ($urandom_range(99) < 3);
    return b;
  endfunction

  // Next poll tick: mostly a plausible shaft and sparse buttons, some pure noise
  function automatic in_item_t make_tick(input bit quiet);
    in_item_t    it;
    logic [31:0] noise;
    logic [3:0]  bits;
    noise = $urandom;
    it    = noise[$bits(in_item_t)-1:0];
    if (!quiet && $urandom_range(99) < 6) begin
      it.stop_button = it.stop_button & ($urandom_range(3) == 0);
      return it;
    end
    if ((last_panel.motor_drive == MOTOR_UP && plant_pos < 2 * (FLOORS - 1)) ||
        (last_panel.motor_drive == MOTOR_DOWN && plant_pos > 0)) begin
      plant_cnt++;
      if (plant_cnt >= plant_step) begin
        plant_pos  += (last_panel.motor_drive == MOTOR_UP) ? 1 : -1;
        plant_cnt  = 0;
        plant_step = $urandom_range(1, 3);
      end
    end
    if (plant_pos % 2 == 0) it.floor_sensor = 3'(plant_pos / 2);
    else if ($urandom_range(3) == 0) it.floor_sensor = 3'($urandom_range(4, 7));
    else it.floor_sensor = 3'b111;
    bits = press_bits();
    it.hall_up_buttons = bits[2:0];
    bits = press_bits();
    it.hall_down_buttons = bits[2:0];
    it.cab_buttons = press_bits();
    if (quiet) begin
      stop_left = 0;
      obst_left = 0;
    end else begin
      if (stop_left == 0 && $urandom_range(149) == 0) begin
        stop_left = $urandom_range(1, 12);
        stop_presses++;
      end
      if (obst_left == 0 && last_panel.door_lamp && $urandom_range(99) < 6)
        obst_left = $urandom_range(1, 4);
    end
    it.stop_button = (stop_left > 0);
    it.obstruction = (obst_left > 0);
    if (stop_left > 0) stop_left--;
    if (obst_left > 0) obst_left--;
    return it;
  endfunction

  task automatic send_tick(input in_item_t it, input bit typed, input out_item_t typed_want);
    out_item_t want;
    logic      was_door;
    while (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    was_door = (car_mode == M_DOOR);
    want = advance_car(it);
    if (!was_door && car_mode == M_DOOR) door_opens++;
    panel_due.push_back(typed ? typed_want : want);
    last_panel = want;
    ticks_sent++;
  endtask

  // Drop valid and wait for every outstanding beat plus the pipe latency
  task automatic settle();
    in_valid <= 1'b0;
    while (panel_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_door_ticks(input logic [DOOR_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en      <= 1'b0;
    door_ticks_set = v;
  endtask

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req) begin
        stall_req  = 1'b0;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 30);
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      beats_checked++;
      if (panel_due.size() == 0) begin
        if (errors < 10) $display("%0t: panel beat with nothing expected", $time);
        errors++;
      end else begin
        want = panel_due.pop_front();
        if (want.motor_drive !== out_item.motor_drive ||
            want.floor_indicator !== out_item.floor_indicator ||
            want.door_lamp !== out_item.door_lamp ||
            want.stop_lamp !== out_item.stop_lamp ||
            want.hall_up_lamps !== out_item.hall_up_lamps ||
            want.hall_down_lamps !== out_item.hall_down_lamps ||
            want.cab_lamps !== out_item.cab_lamps) begin
          if (errors < 10) begin
            $write("%0t: want motor %0d floor %0d door %b stop %b up %b dn %b cab %b, ",
                   $time, want.motor_drive, want.floor_indicator, want.door_lamp,
                   want.stop_lamp, want.hall_up_lamps, want.hall_down_lamps,
                   want.cab_lamps);
            $display("got motor %0d floor %0d door %b stop %b up %b dn %b cab %b",
                     out_item.motor_drive, out_item.floor_indicator,
                     out_item.door_lamp, out_item.stop_lamp, out_item.hall_up_lamps,
                     out_item.hall_down_lamps, out_item.cab_lamps);
          end
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
      $display("elevator_floor_controller_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_item     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    reset_car();
    last_panel  = '0;
    plant_pos   = 0;
    plant_cnt   = 0;
    plant_step  = 1;
    door_plan   = '{16'd1, 16'd0, 16'd4, 16'd2, 16'hFFFF, 16'd9, 16'd3, 16'd30, 16'd1};

    script = '{
      // homing ignores buttons, stop lamp follows stop while homing
      row(3'b111, 3'b111, 3'b111, 4'hF, 1'b0, 1'b0, 1, 1'b1,
          panel(MOTOR_DOWN, 2'd0, 1'b0, 1'b0, 3'b000, 3'b000, 4'h0)),
      row(3'b100, 3'b000, 3'b000, 4'h0, 1'b1, 1'b0, 1, 1'b1,
          panel(MOTOR_DOWN, 2'd0, 1'b0, 1'b1, 3'b000, 3'b000, 4'h0)),
      row(3'b000, 3'b000, 3'b000, 4'h0, 1'b0, 1'b0, 1, 1'b1,
          panel(MOTOR_STOP, 2'd0, 1'b0, 1'b0, 3'b000, 3'b000, 4'h0)),
      row(3'b000, 3'b000, 3'b000, 4'h8, 1'b0, 1'b0, 1, 1'b1,
          panel(MOTOR_UP, 2'd0, 1'b0, 1'b0, 3'b000, 3'b000, 4'h8)),
      // ride up past a down call, stop on the way for a cab call
      row(3'b111, 3'b000, 3'b000, 4'h0, 1'b0, 1'b0, 2, 1'b0, '0),
      row(3'b001, 3'b000, 3'b001, 4'h0, 1'b0, 1'b0, 1, 1'b0, '0),
      row(3'b111, 3'b100, 3'b100, 4'h0, 1'b0, 1'b0, 1, 1'b0, '0),
      row(3'b010, 3'b000, 3'b000, 4'h4, 1'b0, 1'b0, 1, 1'b0, '0),
      row(3'b010, 3'b000, 3'b000, 4'h0, 1'b0, 1'b1, 3, 1'b0, '0),
      row(3'b010, 3'b000, 3'b000, 4'h0, 1'b0, 1'b0, 125, 1'b0, '0),
      row(3'b101, 3'b000, 3'b000, 4'h0, 1'b0, 1'b0, 2, 1'b0, '0),
      // target reached, stop held with the door open, then back down
      row(3'b011, 3'b000, 3'b000, 4'h0, 1'b0, 1'b0, 1, 1'b0, '0),
      row(3'b011, 3'b111, 3'b000, 4'h1, 1'b1, 1'b0, 2, 1'b0, '0),
      row(3'b011, 3'b000, 3'b000, 4'h0, 1'b0, 1'b0, 122, 1'b0, '0),
      // stop between floors, a floor seen while held, door then homing
      row(3'b111, 3'b000, 3'b000, 4'h0, 1'b1, 1'b0, 2, 1'b0, '0),
      row(3'b010, 3'b000, 3'b000, 4'h0, 1'b1, 1'b0, 1, 1'b0, '0),
      row(3'b010, 3'b000, 3'b000, 4'h0, 1'b0, 1'b0, 121, 1'b0, '0),
      row(3'b110, 3'b000, 3'b000, 4'hF, 1'b0, 1'b0, 2, 1'b0, '0),
      row(3'b000, 3'b000, 3'b000, 4'h0, 1'b0, 1'b0, 1, 1'b0, '0),
      // stop while idle at a floor
      row(3'b000, 3'b000, 3'b000, 4'h0, 1'b1, 1'b0, 1, 1'b0, '0),
      row(3'b000, 3'b000, 3'b000, 4'h0, 1'b0, 1'b0, 122, 1'b0, '0),
      // order at the floor the car stands on opens the door at once
      row(3'b000, 3'b001, 3'b000, 4'h1, 1'b0, 1'b0, 1, 1'b0, '0),
      row(3'b000, 3'b000, 3'b000, 4'h0, 1'b0, 1'b0, 121, 1'b0, '0),
      // stop with no floor seen homes straight away on release
      row(3'b111, 3'b000, 3'b000, 4'h0, 1'b1, 1'b0, 1, 1'b0, '0),
      row(3'b111, 3'b000, 3'b000, 4'h0, 1'b0, 1'b0, 1, 1'b0, '0),
      row(3'b000, 3'b000, 3'b000, 4'h0, 1'b0, 1'b0, 1, 1'b0, '0)
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i])
      for (int r = 0; r < script[i].reps; r++)
        send_tick(script[i].tick, script[i].typed, script[i].want);

    plant_pos = 0;
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_door_ticks(door_plan[p]);
      calm = (p == 2);
      for (int i = 0; i < TICKS_PER_PHASE; i++) begin
        if (p == 1 && i == 60) stall_req = 1'b1;
        send_tick(make_tick(1'b0), 1'b0, '0);
      end
    end
    calm = 1'b0;
    settle();

    $display("%0d ticks sent and %0d panel beats checked over %0d door settings plus reset",
             ticks_sent, beats_checked, PHASES);
    $display("%0d door openings, %0d stop presses, %0d failures",
             door_opens, stop_presses, errors);
    if (errors == 0) $display("elevator_floor_controller_tb: clean");
    else $display("elevator_floor_controller_tb: errors");
    $finish;
  end

endmodule
